// ===== sv/skf_pkg.sv =====
// Shared types and constants for the four-channel scalar Kalman smoother.
// Used by the divider, the top level and the port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

	// Channel count and field widths
	localparam int CHANNELS = 4;
	localparam int CH_W     = 2;
	localparam int VAL_W    = 32;
	localparam int MN_W     = 31;
	localparam int PN_W     = 24;
	localparam int FRAC_W   = 24;
	localparam int GAIN_W   = FRAC_W + 1;
	localparam int DEN_W    = VAL_W + 1;
	localparam int MAG_W    = VAL_W + 1;
	localparam int PROD_W   = MAG_W + GAIN_W;
	localparam int STEP_W   = PROD_W + 1 - FRAC_W;
	localparam int EST_W    = STEP_W + 2;
	localparam int SUM_W    = PROD_W + 2;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// Reset values
	localparam logic [MN_W-1:0]  MN_RESET  = 31'd52429;
	localparam logic [VAL_W-1:0] ERR_RESET = 32'd52429;
	localparam logic [PN_W-1:0]  PN_RESET [CHANNELS] = '{
		24'd1677722, 24'd838861, 24'd16777, 24'd16777
	};

	// Fixed-point constants
	localparam logic [GAIN_W-1:0] ONE_Q24  = GAIN_W'(1) << FRAC_W;
	localparam logic [VAL_W-1:0]  EST_MAX  = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0]  EST_MIN  = 32'h8000_0000;

	// Register indexes (byte address divided by four)
	localparam logic [2:0] REG_MEASURE_NOISE = 3'd0;
	localparam logic [2:0] REG_PNOISE_CH0    = 3'd1;
	localparam logic [2:0] REG_PNOISE_CH1    = 3'd2;
	localparam logic [2:0] REG_PNOISE_CH2    = 3'd3;
	localparam logic [2:0] REG_PNOISE_CH3    = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_STEP,
		ST_EST,
		ST_CHG,
		ST_SUM,
		ST_OUT
	} skf_state_t;

	typedef struct packed {
		logic              start;
		logic [VAL_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} skf_div_req_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] gain;
	} skf_div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/scalar_kalman_filter_4ch_top.sv =====
// Top level of the four-channel scalar Kalman smoother: stream ports, APB
// registers, channel state, sequencer and the shared multiplier.
// Depends on skf_pkg and skf_divider.
//
//  Channel   Direction  Contents
//  -------   ---------  ------------------------------------------------------
//  s_*       in         one measurement word per handshake, tuser = channel
//  m_*       out        one estimate word per measurement, tuser = channel
//  APB       in/out     measure_noise at 0x00, process_noise_ch0..ch3 at 0x04..0x10
//
// Each accepted word passes through these states before the next one can be taken:
// ST_IDLE accepts it, ST_PREP sets up, ST_DIV runs the 25-step gain divider, ST_STEP,
// ST_EST and ST_CHG share one 33 x 25 multiplier, ST_SUM sums the new error estimate
// and writes the channel state, and ST_OUT loads the output register. A result
// waiting on m_tready holds the sequencer in its final state but does not block
// acceptance once it is loaded.
// The asynchronous reset restores the default noise weights, zero estimates
// and an error estimate of 0.8 on every channel.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter_4ch_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [skf_pkg::VAL_W-1:0]   s_tdata,   // [31:0] measurement
	input  logic [skf_pkg::CH_W-1:0]    s_tuser,   // [1:0] channel
	// Output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [skf_pkg::VAL_W-1:0]   m_tdata,   // [31:0] estimate
	output logic [skf_pkg::CH_W-1:0]    m_tuser,   // [1:0] out_channel
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [skf_pkg::ADDR_W-1:0]  paddr,
	input  logic [skf_pkg::DATA_W-1:0]  pwdata,
	output logic [skf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import skf_pkg::*;

	// Configuration registers
	logic [MN_W-1:0]   mn_q;
	logic [PN_W-1:0]   pnoise_q [CHANNELS];

	// Per-channel filter state
	logic [VAL_W-1:0]  last_value_q [CHANNELS];
	logic [VAL_W-1:0]  err_est_q    [CHANNELS];

	// Sequencer and working registers
	skf_state_t        state_q, state_d;
	logic [CH_W-1:0]   ch_q;
	logic [VAL_W-1:0]  meas_q;
	logic [MAG_W-1:0]  innov_q;
	logic [GAIN_W-1:0] gain_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;
	logic [VAL_W-1:0]  est_q;

	// Output register
	logic              m_tvalid_q;
	logic [VAL_W-1:0]  m_tdata_q;
	logic [CH_W-1:0]   m_tuser_q;

	skf_div_req_t      div_req;
	skf_div_rsp_t      div_rsp;

	logic              div_start;
	logic              out_load;
	logic [VAL_W-1:0]  e_cur;
	logic [VAL_W-1:0]  last_cur;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  change_diff;
	logic [MAG_W-1:0]  change;
	logic [PROD_W:0]   rnd;
	logic [STEP_W-1:0] step;
	logic [EST_W-1:0]  last_x;
	logic [EST_W-1:0]  est_w;
	logic              sat_hi;
	logic              sat_lo;
	logic [VAL_W-1:0]  est_sat;
	logic [SUM_W-1:0]  total;
	logic [VAL_W-1:0]  err_new;
	logic [MAG_W-1:0]  mul_a;
	logic [GAIN_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              cfg_wr;

	// ------------------------------------------------------------------
	// Configuration port. Writes land on the access cycle; every access
	// completes at once.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mn_q     <= MN_RESET;
			pnoise_q <= PN_RESET;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MEASURE_NOISE: mn_q        <= pwdata[MN_W-1:0];
				REG_PNOISE_CH0:    pnoise_q[0] <= pwdata[PN_W-1:0];
				REG_PNOISE_CH1:    pnoise_q[1] <= pwdata[PN_W-1:0];
				REG_PNOISE_CH2:    pnoise_q[2] <= pwdata[PN_W-1:0];
				REG_PNOISE_CH3:    pnoise_q[3] <= pwdata[PN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MEASURE_NOISE: prdata = DATA_W'(mn_q);
			REG_PNOISE_CH0:    prdata = DATA_W'(pnoise_q[0]);
			REG_PNOISE_CH1:    prdata = DATA_W'(pnoise_q[1]);
			REG_PNOISE_CH2:    prdata = DATA_W'(pnoise_q[2]);
			REG_PNOISE_CH3:    prdata = DATA_W'(pnoise_q[3]);
			default:           prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV:  if (div_rsp.done) state_d = ST_STEP;
			ST_STEP: state_d = ST_EST;
			ST_EST:  state_d = ST_CHG;
			ST_CHG:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_OUT;
			ST_OUT:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready  = 1'b1;
			ST_PREP: div_start = 1'b1;
			ST_OUT:  out_load  = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Gain divider: numerator is the error estimate, denominator e + m.
	// ------------------------------------------------------------------
	assign e_cur         = err_est_q[ch_q];
	assign last_cur      = last_value_q[ch_q];
	assign div_req.start = div_start;
	assign div_req.num   = e_cur;
	assign div_req.den   = {1'b0, e_cur} + DEN_W'(mn_q);

	skf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Datapath. The one multiplier forms, in turn, |innovation| * gain,
	// (1 - gain) * e and |change| * q; its product is registered each cycle.
	// ------------------------------------------------------------------
	assign mag = innov_q[MAG_W-1] ? (~innov_q + 1'b1) : innov_q;

	// Round the step to nearest, ties away from zero, then apply the sign.
	assign rnd    = {1'b0, prod_q} + (PROD_W+1)'(ONE_Q24 >> 1);
	assign step   = rnd[PROD_W:FRAC_W];
	assign last_x = EST_W'($signed(last_cur));
	assign est_w  = innov_q[MAG_W-1] ? (last_x - EST_W'(step)) : (last_x + EST_W'(step));
	assign sat_hi = !est_w[EST_W-1] && (est_w[EST_W-2:VAL_W-1] != '0);
	assign sat_lo = est_w[EST_W-1] && (est_w[EST_W-2:VAL_W-1] != '1);
	assign est_sat = sat_hi ? EST_MAX : (sat_lo ? EST_MIN : est_w[VAL_W-1:0]);

	assign change_diff = {est_q[VAL_W-1], est_q} - {last_cur[VAL_W-1], last_cur};
	assign change      = change_diff[MAG_W-1] ? (~change_diff + 1'b1) : change_diff;

	// New error estimate, rounded from Q40 back to Q16.16 and saturated high.
	assign total   = SUM_W'(acc_q) + SUM_W'(prod_q) + SUM_W'(ONE_Q24 >> 1);
	assign err_new = (total[SUM_W-1:VAL_W+FRAC_W] != '0) ? '1
		: total[VAL_W+FRAC_W-1:FRAC_W];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_STEP: begin
				mul_a = mag;
				mul_b = gain_q;
			end
			ST_EST: begin
				mul_a = MAG_W'(e_cur);
				mul_b = ONE_Q24 - gain_q;
			end
			ST_CHG: begin
				mul_a = change;
				mul_b = GAIN_W'(pnoise_q[ch_q]);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (s_tvalid && s_tready) begin
			ch_q   <= s_tuser;
			meas_q <= s_tdata;
		end
		if (state_q == ST_PREP) begin
			innov_q <= {meas_q[VAL_W-1], meas_q} - {last_cur[VAL_W-1], last_cur};
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			gain_q <= div_rsp.gain;
		end
		if (state_q == ST_EST) begin
			est_q <= est_sat;
		end
		if (state_q == ST_CHG) begin
			acc_q <= prod_q;
		end
	end

	// Channel state is written once the whole update is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_value_q[i] <= '0;
				err_est_q[i]    <= ERR_RESET;
			end
		end else if (state_q == ST_SUM) begin
			last_value_q[ch_q] <= est_q;
			err_est_q[ch_q]    <= err_new;
		end
	end

	// ------------------------------------------------------------------
	// Output register: it holds a finished word while the next one is taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= est_q;
			m_tuser_q <= ch_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== sv/skf_divider.sv =====
// Iterative restoring divider that forms the Kalman gain floor(e * 2^24 / den).
// Depends on skf_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module skf_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skf_pkg::skf_div_req_t req,
	output skf_pkg::skf_div_rsp_t rsp
);
	import skf_pkg::*;

	localparam int REM_W = DEN_W + 1;
	localparam int CNT_W = $clog2(GAIN_W);

	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [GAIN_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              zero_q;

	logic [REM_W-1:0]  diff;
	logic [REM_W-1:0]  nrem;
	logic              ge;

	// As the numerator never exceeds the denominator, the first step yields the
	// 2^24 bit and every later step one fraction bit.
	always_comb begin
		diff = rem_q - {1'b0, den_q};
		ge   = rem_q >= {1'b0, den_q};
		nrem = ge ? diff : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= REM_W'(req.num);
			den_q  <= req.den;
			zero_q <= (req.den == '0);
		end else if (busy_q) begin
			quot_q <= {quot_q[GAIN_W-2:0], ge};
			rem_q  <= {nrem[REM_W-2:0], 1'b0};
		end
	end

	// A zero denominator gives a zero gain, which leaves the channel unchanged.
	assign rsp.done = done_q;
	assign rsp.gain = zero_q ? '0 : quot_q;

endmodule

`default_nettype wire

// ===== sv/skf_checker.sv =====
// Port-level checks for the scalar Kalman smoother, with the bind that
// attaches them to scalar_kalman_filter_4ch_top. Depends on skf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skf_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	input  wire                        s_tready,
	input  wire                        m_tvalid,
	input  wire                        m_tready,
	input  wire [skf_pkg::VAL_W-1:0]   m_tdata,
	input  wire [skf_pkg::CH_W-1:0]    m_tuser
);
	import skf_pkg::*;

	// One word is worked on at a time, so taking a word drops ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is still being filtered");

	// A result never appears in the cycle straight after its word was taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too soon after an accepted word");

	// A stalled result keeps its word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or vanished");

endmodule

bind scalar_kalman_filter_4ch_top skf_checker u_skf_checker (.*);

`default_nettype wire

// ===== sim/scalar_kalman_filter_4ch_top_tb.sv =====
// Self-checking testbench for the four-channel scalar Kalman smoother top level.
// Needs skf_pkg, skf_divider and the RTL of scalar_kalman_filter_4ch_top; nothing else.
`timescale 1ns / 1ps

module scalar_kalman_filter_4ch_top_tb;
	import skf_pkg::*;

	// Register defaults after reset, in the units of the registers themselves
	localparam logic [MN_W-1:0]  DEFAULT_MEASURE_NOISE = 31'd52429;
	localparam logic [PN_W-1:0]  DEFAULT_PROCESS_NOISE [CHANNELS] = '{
		24'd1677722, 24'd838861, 24'd16777, 24'd16777
	};
	localparam logic [VAL_W-1:0] DEFAULT_ERROR = 32'd52429;

	localparam int              FRAC          = 24;
	localparam longint unsigned Q24_UNIT      = 64'd1 << FRAC;
	localparam longint unsigned Q24_HALF      = 64'd1 << (FRAC - 1);
	localparam longint          SAT_HI        = 64'sh0000_0000_7FFF_FFFF;
	localparam longint          SAT_LO        = 64'shFFFF_FFFF_8000_0000;
	localparam longint unsigned ERR_CEILING   = 64'h0000_0000_FFFF_FFFF;

	localparam int RANDOM_PHASES     = 6;
	localparam int WORDS_PER_PHASE   = 110;
	localparam int LONG_HOLD_CYCLES  = 300;
	localparam int WATCHDOG_LIMIT    = 3000;

	localparam logic [VAL_W-1:0] EXTREME_SAMPLES [5] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
	};

	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [VAL_W-1:0] est;
	} filtered_word_t;

	// Tracks the filter state of every channel and the estimates still owed by the block.
	class estimate_ledger;
		logic [MN_W-1:0]         noise_m;
		logic [PN_W-1:0]         noise_q [CHANNELS];
		logic signed [VAL_W-1:0] est_state [CHANNELS];
		logic [VAL_W-1:0]        err_state [CHANNELS];
		filtered_word_t          pending_estimates [$];
		int                      mismatches;

		function new();
			noise_m = DEFAULT_MEASURE_NOISE;
			for (int i = 0; i < CHANNELS; i++) begin
				noise_q[i]   = DEFAULT_PROCESS_NOISE[i];
				est_state[i] = '0;
				err_state[i] = DEFAULT_ERROR;
			end
			mismatches = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		function void write_register(logic [2:0] idx, logic [DATA_W-1:0] value);
			if (idx == REG_MEASURE_NOISE) begin
				noise_m = value[MN_W-1:0];
			end else if (idx >= REG_PNOISE_CH0 && idx <= REG_PNOISE_CH3) begin
				noise_q[idx - REG_PNOISE_CH0] = value[PN_W-1:0];
			end
		endfunction

		// One filter update for the channel of an accepted measurement word.
		function void note_measurement(logic [CH_W-1:0] ch, logic [VAL_W-1:0] meas);
			longint unsigned e, den, gain, mag, step, change, acc;
			longint          last, innov, est;
			filtered_word_t  owed;

			last  = est_state[ch];
			e     = err_state[ch];
			den   = e + noise_m;
			// A zero denominator leaves the gain at zero, so nothing moves.
			gain  = (den == 0) ? 64'd0 : (e << FRAC) / den;
			innov = longint'($signed(meas)) - last;
			mag   = (innov < 0) ? -innov : innov;
			step  = (mag * gain + Q24_HALF) >> FRAC;
			est   = (innov < 0) ? last - longint'(step) : last + longint'(step);
			if (est > SAT_HI) begin
				est = SAT_HI;
			end
			if (est < SAT_LO) begin
				est = SAT_LO;
			end
			change = (est >= last) ? est - last : last - est;
			acc    = (Q24_UNIT - gain) * e + change * noise_q[ch];
			acc    = (acc + Q24_HALF) >> FRAC;
			if (acc > ERR_CEILING) begin
				acc = ERR_CEILING;
			end
			est_state[ch] = VAL_W'(est);
			err_state[ch] = VAL_W'(acc);
			owed.ch  = ch;
			owed.est = VAL_W'(est);
			pending_estimates.push_back(owed);
		endfunction

		function void check_estimate(logic [CH_W-1:0] ch, logic [VAL_W-1:0] est);
			filtered_word_t want;

			if (pending_estimates.size() == 0) begin
				flag($sformatf("estimate word ch=%0d est=%h arrived with none owed", ch, est));
			end else begin
				want = pending_estimates.pop_front();
				if (ch !== want.ch) begin
					flag($sformatf("channel: expected %0d, got %0d", want.ch, ch));
				end
				if (est !== want.est) begin
					flag($sformatf("estimate on ch %0d: expected %h, got %h",
						want.ch, want.est, est));
				end
			end
		endfunction

		function int pending();
			return pending_estimates.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [VAL_W-1:0]    s_tdata;   // [31:0] measurement
	logic [CH_W-1:0]     s_tuser;   // [1:0] channel
	logic                m_tvalid;
	logic                m_tready;
	logic [VAL_W-1:0]    m_tdata;   // [31:0] estimate
	logic [CH_W-1:0]     m_tuser;   // [1:0] out_channel
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	estimate_ledger ledger = new();

	int send_idle_pct = 33;
	int recv_idle_pct = 80;
	bit long_hold     = 1'b0;
	int quiet_cycles  = 0;

	scalar_kalman_filter_4ch_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Both handshakes are sampled here, with the values from before the edge, and any
	// long stretch without a word moving either way ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ledger.note_measurement(s_tuser, s_tdata);
			end
			if (m_tvalid && m_tready) begin
				ledger.check_estimate(m_tuser, m_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Output side: random back-pressure, or one long hold-off when asked for, so that
	// the block fills up and has to refuse measurement words.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Called at a rising edge; returns at the edge at which the word is taken.
	task automatic send_word(input logic [CH_W-1:0] ch, input logic [VAL_W-1:0] meas);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= ch;
		s_tdata  <= meas;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Bits above the register's width carry noise; the block must ignore them.
	// The bus is left idle after the access before the task returns, so back-to-back writes
	// never drive the same signal twice at one edge.
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] bus;

		bus = $urandom();
		if (idx == REG_MEASURE_NOISE) begin
			bus = {bus[DATA_W-1:MN_W], value[MN_W-1:0]};
		end else begin
			bus = {bus[DATA_W-1:PN_W], value[PN_W-1:0]};
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= bus;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		ledger.write_register(idx, bus);
		@(posedge clk);
	endtask

	task automatic write_all_noise(input logic [DATA_W-1:0] m, input logic [PN_W-1:0] q);
		write_reg(REG_MEASURE_NOISE, m);
		for (int c = 0; c < CHANNELS; c++) begin
			write_reg(3'(REG_PNOISE_CH0 + c), DATA_W'(q));
		end
	endtask

	// Stops offering words and waits until every owed estimate has come back.
	task automatic drain_results(input int slack);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
		repeat (slack) @(posedge clk);
	endtask

	// Full-range noise for about a third of words, but a good share tracks the current
	// estimate so that the gain and the error estimate see small innovations too.
	function automatic logic [VAL_W-1:0] next_measurement(input logic [CH_W-1:0] ch);
		int unsigned pick;
		longint      near;

		pick = $urandom_range(99);
		near = longint'(ledger.est_state[ch]) + longint'($urandom_range(2 ** 21)) - 2 ** 20;
		if (pick < 35) begin
			return $urandom();
		end else if (pick < 65) begin
			return VAL_W'(near);
		end else if (pick < 85) begin
			return VAL_W'(longint'($urandom_range(2 ** 19)) - 2 ** 18);
		end else begin
			return EXTREME_SAMPLES[$urandom_range(4)];
		end
	endfunction

	task automatic configure_phase(input int ph);
		logic [DATA_W-1:0] m;
		logic [PN_W-1:0]   q;

		case (ph)
			1: m = 32'h7FFF_FFFF;
			3: m = 32'd1;
			default: begin
				if ($urandom_range(1) == 1) begin
					m = $urandom_range(32'h3_FFFF, 1);
				end else begin
					m = $urandom_range(32'h7FFF_FFFF, 1);
				end
			end
		endcase
		write_reg(REG_MEASURE_NOISE, m);
		for (int c = 0; c < CHANNELS; c++) begin
			if (ph == 1) begin
				q = '0;
			end else if (ph == 3) begin
				q = 24'hFF_FFFF;
			end else begin
				q = PN_W'($urandom());
			end
			write_reg(3'(REG_PNOISE_CH0 + c), DATA_W'(q));
		end
	endtask

	initial begin
		logic [CH_W-1:0] ch;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: every channel once, then the extremes of the measurement.
		for (int c = 0; c < CHANNELS; c++) begin
			send_word(CH_W'(c), 32'h0001_0000);
		end
		send_word(2'd0, 32'h7FFF_FFFF);
		send_word(2'd0, 32'h8000_0000);
		send_word(2'd1, 32'hFFFF_FFFF);
		send_word(2'd1, 32'h0000_0001);
		send_word(2'd2, 32'h8000_0000);
		send_word(2'd3, 32'h7FFF_FFFF);
		drain_results(8);

		// Smallest measurement noise and largest process weights: the gain runs close
		// to one and full-scale swings push the error estimate towards its ceiling.
		write_all_noise(32'd1, 24'hFF_FFFF);
		send_word(2'd0, 32'h7FFF_FFFF);
		send_word(2'd0, 32'h8000_0000);
		send_word(2'd0, 32'h7FFF_FFFF);
		send_word(2'd0, 32'h8000_0000);
		send_word(2'd1, 32'h8000_0000);
		send_word(2'd1, 32'h7FFF_FFFF);
		send_word(2'd2, 32'h0000_0000);
		send_word(2'd3, 32'h1234_5678);
		drain_results(8);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 33;
				recv_idle_pct = 80;
			end else if (ph < 4) begin
				send_idle_pct = 80;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			configure_phase(ph);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (ph == 4 && n == 8) begin
					long_hold = 1'b1;
				end
				ch = CH_W'($urandom_range(CHANNELS - 1));
				send_word(ch, next_measurement(ch));
			end
			drain_results(8);
		end

		// Zero denominator, left to the end because the channel keeps an error estimate
		// of zero afterwards. The first word drives the error estimate of channel 3 to
		// zero; the two after it must leave the estimate where it is.
		write_reg(REG_MEASURE_NOISE, 32'd0);
		write_reg(REG_PNOISE_CH3, 32'd0);
		send_word(2'd3, 32'h0005_0000);
		send_word(2'd3, 32'h7FFF_FFFF);
		send_word(2'd3, 32'h8000_0000);
		drain_results(40);

		if (ledger.mismatches == 0 && ledger.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
